### sv/trs_pkg.sv
// Shared constants and types for the tree rebuild block.
`default_nettype none

package trs_pkg;

  parameter int MAX_NODES    = 1024;
  parameter int LABEL_W      = 11;
  parameter int BITMAP_DEPTH = MAX_NODES + 2;
  parameter int STACK_AW     = $clog2(MAX_NODES);
  parameter int DEPTH_W      = $clog2(MAX_NODES + 1);
  parameter int BM_AW        = $clog2(BITMAP_DEPTH);
  // Entries are refreshed at least once every BITMAP_DEPTH tree starts, so the
  // tag only has to tell apart fewer than 2**EPOCH_W tree starts.
  parameter int EPOCH_W      = $clog2(BITMAP_DEPTH);

  parameter int S_DATA_W = 16;
  parameter int S_USER_W = 1;
  parameter int M_DATA_W = 24;
  parameter int M_USER_W = 2;

  // Bit positions inside m_axis_tuser.
  parameter int U_IS_RIGHT    = 0;
  parameter int U_STACK_ERROR = 1;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               flag;
  } bm_entry_t;

  typedef struct packed {
    logic             en;
    logic [BM_AW-1:0] addr;
    bm_entry_t        data;
  } bm_wr_t;

  typedef struct packed {
    logic                en;
    logic [STACK_AW-1:0] addr;
    logic [LABEL_W-1:0]  data;
  } stk_wr_t;

endpackage

`default_nettype wire

### sv/tree_rebuild_single_pop.sv
// Top level: input stage, link decision, state registers and result register.
//
//  channel  | dir | tdata                         | tuser
//  s_axis   | in  | [10:0] label                  | [0] first_of_tree
//  m_axis   | out | [10:0] parent, [21:11] child  | [0] is_right, [1] stack_error
//
// One item per cycle when not stalled: the label is registered together
// with the bitmap and stack reads; compare, pop/push and lookup produce the result.
// After reset a clearing pass walks the 1026 bitmap entries, one per cycle,
// with s_axis_tready low. Tree starts need no clearing: entries carry a tree tag.
// A result waiting on m_axis stalls the input stage only when a new result is due.
`default_nettype none

module tree_rebuild_single_pop (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [trs_pkg::S_DATA_W-1:0] s_axis_tdata,  // [10:0] label
  input  wire logic [trs_pkg::S_USER_W-1:0] s_axis_tuser,  // [0] first_of_tree
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [trs_pkg::M_DATA_W-1:0]      m_axis_tdata,  // [10:0] parent, [21:11] child
  output logic [trs_pkg::M_USER_W-1:0]      m_axis_tuser   // [0] is_right, [1] stack_error
);

  localparam int LW = trs_pkg::LABEL_W;

  // Input stage.
  logic          stage_valid;
  logic [LW-1:0] stage_label;
  logic          stage_first;
  logic          stage_oob;

  // Block state.
  logic [LW-1:0]                   prev_label;
  logic [trs_pkg::DEPTH_W-1:0]     depth;
  logic [trs_pkg::EPOCH_W-1:0]     epoch;
  logic [trs_pkg::BM_AW-1:0]       scrub_ptr;

  logic                            busy;
  logic                            accept;
  logic                            advance;
  logic [LW-1:0]                   in_label;
  logic [LW:0]                     in_inc;
  logic                            in_oob;

  trs_pkg::bm_wr_t                 bm_wr;
  trs_pkg::bm_entry_t              bm_rd;
  trs_pkg::stk_wr_t                stk_wr;
  logic [LW-1:0]                   stk_rd;
  logic [trs_pkg::DEPTH_W-1:0]     stk_rd_depth;

  logic [LW:0]                     lab_inc;
  logic                            is_left;
  logic                            pop;
  logic                            err;
  logic                            left_wr;
  logic                            lookup;
  logic                            push_en;
  logic [trs_pkg::DEPTH_W-1:0]     depth_mid;
  logic [trs_pkg::DEPTH_W-1:0]     depth_next;
  logic [trs_pkg::EPOCH_W-1:0]     epoch_next;
  logic [LW-1:0]                   parent;

  assign advance       = stage_valid && (stage_first || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !busy && (!stage_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_label = s_axis_tdata[LW-1:0];
  assign in_inc   = {1'b0, in_label} + (LW + 1)'(1);
  assign in_oob   = in_inc >= (LW + 1)'(trs_pkg::BITMAP_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_label <= in_label;
      stage_first <= s_axis_tuser[0];
      stage_oob   <= in_oob;
    end
  end

  // Link decision for the staged label.
  always_comb begin
    lab_inc   = {1'b0, stage_label} + (LW + 1)'(1);
    is_left   = !stage_first && (prev_label > stage_label);
    err       = !stage_first && !is_left && (depth == '0);
    pop       = !stage_first && !is_left && (depth != '0);
    left_wr   = is_left && ({1'b0, prev_label} < (LW + 1)'(trs_pkg::BITMAP_DEPTH));

    if (stage_first) begin
      depth_mid = '0;
    end else if (pop) begin
      depth_mid = depth - trs_pkg::DEPTH_W'(1);
    end else begin
      depth_mid = depth;
    end

    // The own left-link write is seen by the successor lookup in the same step.
    if (stage_oob) begin
      lookup = 1'b0;
    end else if (left_wr && {1'b0, prev_label} == lab_inc) begin
      lookup = (stage_label != '0);
    end else begin
      lookup = (bm_rd.epoch == epoch) && bm_rd.flag;
    end

    push_en    = (stage_first || (!err && !lookup)) &&
                 (depth_mid != trs_pkg::DEPTH_W'(trs_pkg::MAX_NODES));
    depth_next = depth_mid + trs_pkg::DEPTH_W'(push_en);
    epoch_next = stage_first ? epoch + trs_pkg::EPOCH_W'(1) : epoch;

    if (is_left) begin
      parent = prev_label;
    end else if (pop) begin
      parent = stk_rd;
    end else begin
      parent = '0;
    end
  end

  // A tree start refreshes one bitmap entry under the new tag, so no entry
  // keeps a tag old enough to alias after the counter wraps.
  always_comb begin
    bm_wr = '0;
    if (advance && stage_first) begin
      bm_wr.en         = 1'b1;
      bm_wr.addr       = scrub_ptr;
      bm_wr.data.epoch = epoch_next;
      bm_wr.data.flag  = 1'b0;
    end else if (advance && left_wr) begin
      bm_wr.en         = 1'b1;
      bm_wr.addr       = prev_label[trs_pkg::BM_AW-1:0];
      bm_wr.data.epoch = epoch;
      bm_wr.data.flag  = (stage_label != '0);
    end
  end

  always_comb begin
    stk_wr.en    = advance && push_en;
    stk_wr.addr  = depth_mid[trs_pkg::STACK_AW-1:0];
    stk_wr.data  = stage_label;
    stk_rd_depth = (advance ? depth_next : depth) - trs_pkg::DEPTH_W'(1);
  end

  trs_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && !in_oob),
    .rd_addr (in_inc[trs_pkg::BM_AW-1:0]),
    .wr      (bm_wr),
    .busy    (busy),
    .rd_data (bm_rd)
  );

  trs_stack u_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (stk_rd_depth[trs_pkg::STACK_AW-1:0]),
    .wr      (stk_wr),
    .rd_data (stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_label <= '0;
      depth      <= '0;
      epoch      <= '0;
      scrub_ptr  <= '0;
    end else if (advance) begin
      prev_label <= stage_label;
      depth      <= depth_next;
      epoch      <= epoch_next;
      if (stage_first) begin
        if (scrub_ptr == trs_pkg::BM_AW'(trs_pkg::BITMAP_DEPTH - 1)) begin
          scrub_ptr <= '0;
        end else begin
          scrub_ptr <= scrub_ptr + trs_pkg::BM_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && !stage_first) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !stage_first) begin
      m_axis_tdata                          <= trs_pkg::M_DATA_W'({stage_label, parent});
      m_axis_tuser[trs_pkg::U_IS_RIGHT]     <= !is_left;
      m_axis_tuser[trs_pkg::U_STACK_ERROR]  <= err;
    end
  end

endmodule

`default_nettype wire

### sv/trs_bitmap.sv
// Has-left-child map: tagged entries, clearing pass after reset, registered read.
`default_nettype none

module trs_bitmap (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [trs_pkg::BM_AW-1:0] rd_addr,
  input  wire trs_pkg::bm_wr_t           wr,
  output logic                           busy,
  output trs_pkg::bm_entry_t             rd_data
);

  trs_pkg::bm_entry_t mem [trs_pkg::BITMAP_DEPTH];

  logic [trs_pkg::BM_AW-1:0] clr_addr;
  trs_pkg::bm_wr_t           port;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == trs_pkg::BM_AW'(trs_pkg::BITMAP_DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + trs_pkg::BM_AW'(1);
      end
    end
  end

  always_comb begin
    if (busy) begin
      port.en   = 1'b1;
      port.addr = clr_addr;
      port.data = '0;
    end else begin
      port = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (port.en) begin
      mem[port.addr] <= port.data;
    end
  end

  // A read that meets a write to the same entry returns the new value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (port.en && port.addr == rd_addr) begin
        rd_data <= port.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

### sv/trs_stack.sv
// Parent stack memory with registered read and write-to-read forwarding.
`default_nettype none

module trs_stack (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [trs_pkg::STACK_AW-1:0] rd_addr,
  input  wire trs_pkg::stk_wr_t             wr,
  output logic [trs_pkg::LABEL_W-1:0]       rd_data
);

  logic [trs_pkg::LABEL_W-1:0] mem [trs_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == rd_addr) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

### sv/trs_checker.sv
// Port-level checker for the tree rebuild block, bound to the top level.
`default_nettype none

module trs_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [trs_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic [trs_pkg::M_USER_W-1:0] m_axis_tuser
);

  localparam int LW = trs_pkg::LABEL_W;

  // A result that waits keeps its transaction unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An error result is a right link with parent zero.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[trs_pkg::U_STACK_ERROR] |->
      m_axis_tuser[trs_pkg::U_IS_RIGHT] && (m_axis_tdata[LW-1:0] == '0))
    else $error("stack error result malformed");

  // A left link always hangs a smaller label under a larger one.
  a_left: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[trs_pkg::U_IS_RIGHT] |->
      m_axis_tdata[LW-1:0] > m_axis_tdata[2*LW-1:LW])
    else $error("left link with parent not above child");

  // Reset empties the result register.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // The bitmap clearing pass keeps the input closed right after reset.
  a_clear: assert property (@(posedge clk) $fell(rst) |-> !s_axis_tready)
    else $error("input open during clearing pass");

endmodule

bind tree_rebuild_single_pop trs_checker u_trs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
